// ----- rtl/core/tcc_pkg.sv -----
// Shared types and constants for the text console with cursor and scroll.
package tcc_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] BLANK_RESET = 8'h0E;
  localparam logic [7:0] SPACE_CODE  = 8'h20;

  // Command codes carried in the input tuser
  typedef enum logic [1:0] {
    CMD_PUT     = 2'd0,
    CMD_NEWLINE = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_PUT,
    ST_SCROLL,
    ST_SCROLL_TAIL,
    ST_FILL,
    ST_CLEAR,
    ST_RESULT
  } state_t;

endpackage

// ----- rtl/core/text_console_cursor_scroll.sv -----
// Text console: screen cell memory, linear cursor, scroll and clear sequencer.
// A newline goes straight to its result; a put or read first passes its write or read
//   state. A scroll (rows moved up, bottom row filled with blanks) runs ahead of a put
//   or newline that needs it, and a clear zeroes every cell. A new command is taken only in
//   idle, once the last result is loaded; scroll and clear walk memory a cell a cycle.
// Reset: cursor homes, blank attribute returns to 0x0E, then a clearing pass zeroes
//   the memory with in_tready low (cfg writes still taken).
module text_console_cursor_scroll #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: blank attribute
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // command stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] char_code, [15:8] color, [26:16] cell_index
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [10:0] cursor_position, [18:11] read_char,
                                  // [26:19] read_color
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int COLW  = $clog2(COLUMNS + 1);

  localparam logic [CW-1:0]   CUR_END   = CW'(CELLS);
  localparam logic [CW-1:0]   CUR_LAST  = CW'(CELLS - COLUMNS);
  localparam logic [CW:0]     NL_END    = (CW + 1)'(CELLS);
  localparam logic [CW:0]     NL_COLS   = (CW + 1)'(COLUMNS);
  localparam logic [AW-1:0]   ADDR_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0]   ADDR_COLS = AW'(COLUMNS);
  localparam logic [COLW-1:0] COL_LAST  = COLW'(COLUMNS - 1);

  // Cell memory
  logic [15:0] mem [CELLS];
  logic [15:0] mem_q_r;

  tcc_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]   cursor_r;
  logic [COLW-1:0] col_r;
  logic [7:0]      blank_r;
  logic [AW-1:0]   sw_r;
  logic [AW-1:0]   dst_r;
  logic            pend_r;
  tcc_pkg::cmd_t   mode_r;
  logic [7:0]      char_r;
  logic [7:0]      color_r;
  logic            rd_ok_r;
  logic [15:0]     cell_r;
  logic            out_valid_r;
  logic [31:0]     out_data_r;

  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [15:0]     mem_wd;
  logic            mem_re;
  logic [AW-1:0]   mem_ra;

  tcc_pkg::cmd_t   in_mode;
  logic [10:0]     in_idx;
  logic            in_fire;
  logic            idx_ok;
  logic [CW:0]     nl_target;
  logic            nl_scroll;
  logic            put_scroll;
  logic            out_free;

  assign in_mode    = tcc_pkg::cmd_t'(in_tuser);
  assign in_idx     = in_tdata[26:16];
  assign in_tready  = (state_r == tcc_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign idx_ok     = (32'(in_idx) < 32'(CELLS));
  assign nl_target  = (CW + 1)'(cursor_r) + NL_COLS - (CW + 1)'(col_r);
  assign nl_scroll  = (nl_target >= NL_END);
  assign put_scroll = (cursor_r == CUR_END);
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcc_pkg::ST_INIT: begin
        if (dst_r == ADDR_LAST) state_nxt = tcc_pkg::ST_IDLE;
      end
      tcc_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            tcc_pkg::CMD_PUT:     state_nxt = put_scroll ? tcc_pkg::ST_SCROLL : tcc_pkg::ST_PUT;
            tcc_pkg::CMD_NEWLINE: state_nxt = nl_scroll ? tcc_pkg::ST_SCROLL : tcc_pkg::ST_RESULT;
            tcc_pkg::CMD_CLEAR:   state_nxt = tcc_pkg::ST_CLEAR;
            default:              state_nxt = tcc_pkg::ST_READ;
          endcase
        end
      end
      tcc_pkg::ST_READ:   state_nxt = tcc_pkg::ST_RESULT;
      tcc_pkg::ST_PUT:    state_nxt = tcc_pkg::ST_RESULT;
      tcc_pkg::ST_SCROLL: begin
        if (sw_r == ADDR_LAST) state_nxt = tcc_pkg::ST_SCROLL_TAIL;
      end
      tcc_pkg::ST_SCROLL_TAIL: state_nxt = tcc_pkg::ST_FILL;
      tcc_pkg::ST_FILL: begin
        if (dst_r == ADDR_LAST) begin
          state_nxt = (mode_r == tcc_pkg::CMD_PUT) ? tcc_pkg::ST_PUT : tcc_pkg::ST_RESULT;
        end
      end
      tcc_pkg::ST_CLEAR: begin
        if (dst_r == ADDR_LAST) state_nxt = tcc_pkg::ST_RESULT;
      end
      tcc_pkg::ST_RESULT: begin
        if (out_free) state_nxt = tcc_pkg::ST_IDLE;
      end
      default: state_nxt = tcc_pkg::ST_INIT;
    endcase
  end

  // Memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = dst_r;
    mem_wd = 16'h0000;
    mem_re = 1'b0;
    mem_ra = sw_r;
    case (state_r)
      tcc_pkg::ST_INIT, tcc_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      tcc_pkg::ST_IDLE: begin
        mem_re = in_fire && (in_mode == tcc_pkg::CMD_READ) && idx_ok;
        mem_ra = AW'(in_idx);
      end
      tcc_pkg::ST_PUT: begin
        mem_we = 1'b1;
        mem_wa = cursor_r[AW-1:0];
        mem_wd = {color_r, char_r};
      end
      tcc_pkg::ST_SCROLL: begin
        mem_re = 1'b1;
        mem_we = pend_r;
        mem_wd = mem_q_r;
      end
      tcc_pkg::ST_SCROLL_TAIL: begin
        mem_we = pend_r;
        mem_wd = mem_q_r;
      end
      tcc_pkg::ST_FILL: begin
        mem_we = 1'b1;
        mem_wd = {blank_r, tcc_pkg::SPACE_CODE};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q_r <= mem[mem_ra];
  end

  // Blank attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_r <= tcc_pkg::BLANK_RESET;
    end else if (cfg_wr_en) begin
      blank_r <= cfg_wr_data;
    end
  end

  // Sequencer, cursor and sweep counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tcc_pkg::ST_INIT;
      cursor_r <= '0;
      col_r    <= '0;
      sw_r     <= '0;
      dst_r    <= '0;
      pend_r   <= 1'b0;
      mode_r   <= tcc_pkg::CMD_PUT;
      rd_ok_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == tcc_pkg::ST_SCROLL);
      if (mem_we && (state_r != tcc_pkg::ST_PUT)) dst_r <= dst_r + 1'b1;
      if (state_r == tcc_pkg::ST_SCROLL) sw_r <= sw_r + 1'b1;
      case (state_r)
        tcc_pkg::ST_IDLE: begin
          if (in_fire) begin
            mode_r  <= in_mode;
            rd_ok_r <= idx_ok;
            dst_r   <= '0;
            sw_r    <= ADDR_COLS;
            case (in_mode)
              tcc_pkg::CMD_PUT: begin
                // pull back a row ahead of the scroll, column already zero
                if (put_scroll) cursor_r <= CUR_LAST;
              end
              tcc_pkg::CMD_NEWLINE: begin
                cursor_r <= nl_scroll ? CW'(nl_target - NL_COLS) : CW'(nl_target);
                col_r    <= '0;
              end
              tcc_pkg::CMD_CLEAR: begin
                cursor_r <= '0;
                col_r    <= '0;
              end
              default: begin
                cursor_r <= cursor_r;
              end
            endcase
          end
        end
        tcc_pkg::ST_PUT: begin
          cursor_r <= cursor_r + 1'b1;
          col_r    <= (col_r == COL_LAST) ? '0 : col_r + 1'b1;
        end
        default: begin
          cursor_r <= cursor_r;
        end
      endcase
    end
  end

  // Hold command payload and the cell seen by a read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      char_r  <= in_tdata[7:0];
      color_r <= in_tdata[15:8];
      cell_r  <= 16'h0000;
    end
    if (state_r == tcc_pkg::ST_READ) begin
      cell_r <= rd_ok_r ? mem_q_r : 16'h0000;
    end
  end

  // Output register: load the result once the slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == tcc_pkg::ST_RESULT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == tcc_pkg::ST_RESULT) && out_free) begin
      out_data_r <= {5'b0, cell_r[15:8], cell_r[7:0], 11'(cursor_r)};
    end
  end

  // Column tracker stays inside a row
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_LAST)
    else $error("column counter out of range");

  // Cursor never passes the end of the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CUR_END)
    else $error("cursor beyond end of screen");

  // A put write always lands inside the screen
  a_put_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcc_pkg::ST_PUT) |-> (cursor_r < CUR_END))
    else $error("put at end of screen");

  // No read and write of one cell in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re && (mem_wa == mem_ra)))
    else $error("read and write collide on one cell");

  // The fill pass only touches the bottom row
  a_fill_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcc_pkg::ST_FILL) |-> (32'(dst_r) >= 32'(CELLS - COLUMNS)))
    else $error("fill outside bottom row");

  // A scroll ahead of a put leaves the cursor one row up from the end
  a_put_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_mode == tcc_pkg::CMD_PUT) && put_scroll)
      |=> (state_r == tcc_pkg::ST_SCROLL) && (cursor_r == CUR_LAST))
    else $error("put did not scroll first");

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the text console with cursor, scroll and clear.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS  = tcc_pkg::COLUMNS_DEF;
  localparam int CELLS = tcc_pkg::COLUMNS_DEF * tcc_pkg::ROWS_DEF;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic [7:0]  read_char;
    logic [7:0]  read_color;
  } console_result_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = 32'h0;   // [7:0] char_code, [15:8] color, [26:16] cell_index
  logic [1:0]  in_tuser    = 2'b00;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;             // [10:0] cursor_position, [18:11] read_char,
                                      // [26:19] read_color

  // Mirror of the console state, advanced once per accepted command
  logic [15:0]     screen_mirror [CELLS];
  int              cursor_mirror = 0;
  logic [7:0]      blank_attr_mirror = tcc_pkg::BLANK_RESET;
  console_result_t expected_results [$];
  int              mismatch_count = 0;

  int          burst_left = 0;
  int unsigned hold_request = 0;

  text_console_cursor_scroll i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    foreach (screen_mirror[i]) screen_mirror[i] = '0;
  end

  // Random byte and random cell index for fields a command ignores
  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [10:0] rand_index();
    return 11'($urandom);
  endfunction

  // Move every row up, blank the bottom row, pull the cursor back a row
  function automatic void scroll_mirror();
    for (int i = 0; i + COLS < CELLS; i++) screen_mirror[i] = screen_mirror[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) begin
      screen_mirror[i] = {blank_attr_mirror, tcc_pkg::SPACE_CODE};
    end
    cursor_mirror = (cursor_mirror >= COLS) ? cursor_mirror - COLS : 0;
  endfunction

  // Apply one command to the mirror and return the result it should produce
  function automatic console_result_t console_predict(tcc_pkg::cmd_t mode,
                                                      logic [7:0] char_code,
                                                      logic [7:0] color,
                                                      logic [10:0] cell_index);
    console_result_t res = '0;
    case (mode)
      tcc_pkg::CMD_PUT: begin
        if (cursor_mirror >= CELLS) scroll_mirror();
        screen_mirror[cursor_mirror] = {color, char_code};
        cursor_mirror++;
      end
      tcc_pkg::CMD_NEWLINE: begin
        cursor_mirror += COLS - (cursor_mirror % COLS);
        if (cursor_mirror >= CELLS) scroll_mirror();
      end
      tcc_pkg::CMD_CLEAR: begin
        foreach (screen_mirror[i]) screen_mirror[i] = '0;
        cursor_mirror = 0;
      end
      default: begin
        if (cell_index < CELLS) begin
          res.read_char  = screen_mirror[cell_index][7:0];
          res.read_color = screen_mirror[cell_index][15:8];
        end
      end
    endcase
    res.cursor_position = cursor_mirror[10:0];
    return res;
  endfunction

  // Offer one command in bursts with random gaps; record its result on acceptance
  task automatic send_command(input tcc_pkg::cmd_t mode, input logic [7:0] char_code,
                              input logic [7:0] color, input logic [10:0] cell_index);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {5'b0, cell_index, color, char_code};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(console_predict(mode, char_code, color, cell_index));
    if (burst_left == 0) in_tvalid <= 1'b0;
  endtask

  // Stop offering and wait until every outstanding result has arrived
  task automatic drain_results();
    if (burst_left != 0) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
    end
    do @(negedge clk); while (expected_results.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_blank_attribute(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    blank_attr_mirror = value;
    @(posedge clk);
  endtask

  // Random command, weighted by where the cursor stands
  task automatic send_random_command();
    int            pick;
    int            lo;
    int            hi;
    tcc_pkg::cmd_t mode;
    logic [10:0]   idx;
    pick = $urandom_range(0, 199);
    if (cursor_mirror < CELLS - 2 * COLS) begin
      mode = (pick < 84) ? tcc_pkg::CMD_PUT : (pick < 144) ? tcc_pkg::CMD_NEWLINE :
             (pick < 199) ? tcc_pkg::CMD_READ : tcc_pkg::CMD_CLEAR;
    end else begin
      mode = (pick < 116) ? tcc_pkg::CMD_PUT : (pick < 124) ? tcc_pkg::CMD_NEWLINE :
             (pick < 198) ? tcc_pkg::CMD_READ : tcc_pkg::CMD_CLEAR;
    end
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      idx = rand_index();
    end else if (pick < 10) begin
      idx = 11'($urandom_range(0, CELLS - 1));
    end else begin
      lo  = (cursor_mirror > 100) ? cursor_mirror - 100 : 0;
      hi  = (cursor_mirror + 3 > 2047) ? 2047 : cursor_mirror + 3;
      idx = 11'($urandom_range(lo, hi));
    end
    send_command(mode, rand_byte(), rand_byte(), idx);
  endtask

  // Fresh screen: extremes of every field, each command, reads out of range
  task automatic test_directed();
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd0);
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd1999);
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd2000);
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd2047);
    send_command(tcc_pkg::CMD_PUT, 8'h00, 8'h00, rand_index());
    send_command(tcc_pkg::CMD_PUT, 8'hFF, 8'hFF, rand_index());
    send_command(tcc_pkg::CMD_PUT, 8'h5A, 8'hA5, rand_index());
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd0);
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd1);
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd2);
    send_command(tcc_pkg::CMD_NEWLINE, rand_byte(), rand_byte(), rand_index());
    send_command(tcc_pkg::CMD_NEWLINE, rand_byte(), rand_byte(), rand_index());
    send_command(tcc_pkg::CMD_PUT, 8'h41, 8'h07, rand_index());
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd160);
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd1024);
    send_command(tcc_pkg::CMD_CLEAR, rand_byte(), rand_byte(), rand_index());
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd1);
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd160);
    send_command(tcc_pkg::CMD_NEWLINE, rand_byte(), rand_byte(), rand_index());
    send_command(tcc_pkg::CMD_PUT, rand_byte(), rand_byte(), rand_index());
    drain_results();
  endtask

  // Fill the bottom row, newline at the very end, then put and check the blanked row
  task automatic test_end_of_screen();
    write_blank_attribute(8'hFF);
    send_command(tcc_pkg::CMD_CLEAR, rand_byte(), rand_byte(), rand_index());
    repeat (tcc_pkg::ROWS_DEF - 1) begin
      send_command(tcc_pkg::CMD_NEWLINE, rand_byte(), rand_byte(), rand_index());
    end
    repeat (COLS) send_command(tcc_pkg::CMD_PUT, rand_byte(), rand_byte(), rand_index());
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd1999);
    send_command(tcc_pkg::CMD_NEWLINE, rand_byte(), rand_byte(), rand_index());
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd1919);
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd1999);
    send_command(tcc_pkg::CMD_PUT, rand_byte(), rand_byte(), rand_index());
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd1920);
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd1921);
    drain_results();
    write_blank_attribute(8'h00);
    send_command(tcc_pkg::CMD_NEWLINE, rand_byte(), rand_byte(), rand_index());
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd1999);
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd1919);
    send_command(tcc_pkg::CMD_READ, rand_byte(), rand_byte(), 11'd1840);
    drain_results();
  endtask

  // Hold the result side off for a long stretch, then let the sender pause mid-run
  task automatic test_back_pressure();
    write_blank_attribute(8'h3C);
    hold_request++;
    repeat (60) send_random_command();
    drain_results();
    repeat (30) send_random_command();
    drain_results();
  endtask

  // Long random run in phases, a new blank attribute before each phase
  task automatic test_random();
    for (int phase = 0; phase < 10; phase++) begin
      drain_results();
      if (phase == 0) begin
        write_blank_attribute(8'h00);
      end else if (phase == 1) begin
        write_blank_attribute(8'hFF);
      end else begin
        write_blank_attribute(rand_byte());
      end
      repeat (167) send_random_command();
    end
    drain_results();
  endtask

  // Result side: stall on stretches of its own, or hold off when a test asks
  always @(posedge clk) begin : result_stall
    int unsigned hold_served;
    int unsigned hold_left;
    int unsigned stretch_left;
    int unsigned stall_pct;
    if (hold_request != hold_served) begin
      hold_served = hold_request;
      hold_left   = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(8, 80);
        stall_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 75);
      end else begin
        stretch_left--;
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    console_result_t got;
    console_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[10:0], out_tdata[18:11], out_tdata[26:19]};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        if (got.cursor_position !== want.cursor_position) begin
          mismatch_count++;
          $display("%0t: cursor_position expected %0d actual %0d", $time,
                   want.cursor_position, got.cursor_position);
        end
        if (got.read_char !== want.read_char) begin
          mismatch_count++;
          $display("%0t: read_char expected %h actual %h", $time,
                   want.read_char, got.read_char);
        end
        if (got.read_color !== want.read_color) begin
          mismatch_count++;
          $display("%0t: read_color expected %h actual %h", $time,
                   want.read_color, got.read_color);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_blank_attribute(tcc_pkg::BLANK_RESET);
    test_directed();
    test_end_of_screen();
    test_back_pressure();
    test_random();
    drain_results();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS text_console_cursor_scroll");
    end else begin
      $display("FAIL text_console_cursor_scroll");
    end
    $finish;
  end

  // Give up well beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("FAIL text_console_cursor_scroll");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tcc_pkg.sv
rtl/core/text_console_cursor_scroll.sv
bench/testbench.sv
